[src/i2c_master_byte_sequencer_macros.svh]
// Assertion helpers for the I2C byte sequencer.
// Each macro expects clk and rst_n in scope.
`ifndef I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2CMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cms: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define I2CMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cms: next-cycle check failed");

`endif

[src/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared codes, constants and payload types of the I2C byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_START = 2'd0;
  localparam op_t OP_STOP  = 2'd1;
  localparam op_t OP_WRITE = 2'd2;
  localparam op_t OP_READ  = 2'd3;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned PHASE_W = 5;

  localparam logic [TICK_W-1:0]  PHASE_TICKS_RST = 16'd5;
  localparam logic [PHASE_W-1:0] PHASES_COND     = 5'd4;   // start, stop
  localparam logic [PHASE_W-1:0] PHASES_BYTE     = 5'd18;  // write, read
  localparam logic [PHASE_W-1:0] PHASE_ACK_LOW   = 5'd16;
  localparam logic [PHASE_W-1:0] PHASE_ACK_HIGH  = 5'd17;
  localparam logic [7:0]         MSB_MASK        = 8'h80;

  typedef struct packed {
    logic       cmd_valid;
    op_t        action;
    logic       send_ack;
    logic [7:0] write_byte;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       cmd_taken;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } res_t;

endpackage

`default_nettype wire

[src/i2cms_in_if.sv]
// ----------------------------------------------------------------------------
// i2cms_in_if
// Tick channel into the sequencer: one bus tick with command and SDA sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_in_if import i2cms_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  op_t        action;
  logic       send_ack;
  logic [7:0] write_byte;
  logic       sda_in;

  modport source (output valid, cmd_valid, action, send_ack, write_byte, sda_in,
                  input ready);
  modport sink   (input valid, cmd_valid, action, send_ack, write_byte, sda_in,
                  output ready);
endinterface

`default_nettype wire

[src/i2cms_out_if.sv]
// ----------------------------------------------------------------------------
// i2cms_out_if
// Result channel out of the sequencer: line drives and status for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_out_if import i2cms_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       cmd_taken;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_seen;

  modport source (output valid, scl_level, sda_level, busy_res, cmd_taken, done_res,
                  read_byte, ack_seen, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, cmd_taken, done_res,
                  read_byte, ack_seen, output ready);
endinterface

`default_nettype wire

[src/i2cms_core.sv]
// ----------------------------------------------------------------------------
// i2cms_core
// Sequencer state and one-tick step: phase timer, line drives, bit shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_core import i2cms_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire cmd_t              item,
  input  wire logic [TICK_W-1:0] phase_ticks,
  output res_t                   res
);

  logic [TICK_W-1:0]  tick_r,  tick_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  op_t                op_r,    op_nxt;
  logic               act_r,   act_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic               ackc_r,  ackc_nxt;
  logic               ackf_r,  ackf_nxt;
  logic               scl_r,   scl_nxt;
  logic               sda_r,   sda_nxt;
  logic [7:0]         hold_r,  hold_nxt;

  logic [TICK_W-1:0]  limit;
  logic               taken;
  logic               done;
  logic [1:0]         drv;

  function automatic logic [PHASE_W-1:0] phase_total(op_t op);
    return (op == OP_WRITE || op == OP_READ) ? PHASES_BYTE : PHASES_COND;
  endfunction

  // Returns {scl, sda} after the drive of phase p.
  function automatic logic [1:0] drive_phase(op_t op, logic [PHASE_W-1:0] p,
                                             logic [7:0] sh, logic ackc,
                                             logic scl, logic sda);
    logic c;
    logic d;
    c = scl;
    d = sda;
    case (op)
      OP_START: begin
        if (p == 5'd0)      d = 1'b1;
        else if (p == 5'd1) c = 1'b1;
        else if (p == 5'd2) d = 1'b0;
        else                c = 1'b0;
      end
      OP_STOP: begin
        if (p == 5'd0)      c = 1'b0;
        else if (p == 5'd1) d = 1'b0;
        else if (p == 5'd2) c = 1'b1;
        else                d = 1'b1;
      end
      default: begin
        if (p < PHASE_ACK_LOW) begin
          if (p[0]) begin
            c = 1'b1;
          end else begin
            if (p != 5'd0) c = 1'b0;
            if (op == OP_WRITE)  d = |(sh & (MSB_MASK >> p[3:1]));
            else if (p == 5'd0)  d = 1'b1;
          end
        end else if (p == PHASE_ACK_LOW) begin
          c = 1'b0;
          d = (op == OP_WRITE) ? 1'b1 : ~ackc;
        end else begin
          c = 1'b1;
        end
      end
    endcase
    return {c, d};
  endfunction

  always_comb begin
    limit     = (phase_ticks == '0) ? 16'd1 : phase_ticks;
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    act_nxt   = act_r;
    shift_nxt = shift_r;
    ackc_nxt  = ackc_r;
    ackf_nxt  = ackf_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    hold_nxt  = hold_r;
    taken     = 1'b0;
    done      = 1'b0;
    drv       = {scl_r, sda_r};

    if (!act_r) begin
      if (item.cmd_valid) begin
        taken     = 1'b1;
        act_nxt   = 1'b1;
        op_nxt    = item.action;
        shift_nxt = (item.action == OP_WRITE) ? item.write_byte : 8'd0;
        ackc_nxt  = item.send_ack;
        phase_nxt = '0;
        tick_nxt  = '0;
        drv       = drive_phase(item.action, 5'd0, shift_nxt, item.send_ack,
                                scl_r, sda_r);
        scl_nxt   = drv[1];
        sda_nxt   = drv[0];
      end
    end else begin
      tick_nxt = tick_r + 16'd1;
      if (tick_nxt >= limit) begin
        tick_nxt  = '0;
        phase_nxt = phase_r + 5'd1;
        if (phase_nxt >= phase_total(op_r)) begin
          if (op_r == OP_WRITE || op_r == OP_READ) scl_nxt = 1'b0;
          if (op_r == OP_READ) hold_nxt = shift_r;
          act_nxt   = 1'b0;
          phase_nxt = '0;
          done      = 1'b1;
        end else begin
          drv     = drive_phase(op_r, phase_nxt, shift_r, ackc_r, scl_r, sda_r);
          scl_nxt = drv[1];
          sda_nxt = drv[0];
        end
      end
    end

    // Sample SDA on the last tick of an SCL-high phase.
    if (act_nxt && !taken && phase_nxt[0] &&
        ({1'b0, tick_nxt} + 17'd1 >= {1'b0, limit})) begin
      if (op_nxt == OP_READ && phase_nxt < PHASE_ACK_LOW)
        shift_nxt = {shift_nxt[6:0], item.sda_in};
      else if (op_nxt == OP_WRITE && phase_nxt == PHASE_ACK_HIGH)
        ackf_nxt = ~item.sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      phase_r <= '0;
      op_r    <= OP_START;
      act_r   <= 1'b0;
      shift_r <= '0;
      ackc_r  <= 1'b0;
      ackf_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      hold_r  <= '0;
    end else if (step) begin
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      act_r   <= act_nxt;
      shift_r <= shift_nxt;
      ackc_r  <= ackc_nxt;
      ackf_r  <= ackf_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = act_nxt;
    res.cmd_taken = taken;
    res.done_res  = done;
    res.read_byte = hold_nxt;
    res.ack_seen  = ackf_nxt;
  end

endmodule

`default_nettype wire

[src/i2c_master_byte_sequencer.sv]
// Byte-level I2C master. Every transfer on in_ch is one tick of the bus
// timer and carries an optional command (start, stop, write a byte, read a
// byte with ACK or NAK) plus the sampled SDA level; every tick gives exactly
// one transfer on out_ch with the SCL and SDA drives (1 = released), busy,
// command-taken, a one-tick done pulse, the last read byte and the last
// write's ack. Commands offered while busy are dropped. Each bus phase lasts
// cfg phase_ticks ticks (0 counts as 1); start and stop take 4 phases, a
// byte write or read 18. Rate: one transfer in and one out per clock cycle
// when out_ch is never stalled. A tick passes the input register, the single
// step of logic and the result register, in that order. Write phase_ticks
// only while no tick is in flight.
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// Top level: input register, sequencer core, result register, config.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_sequencer_macros.svh"

module i2c_master_byte_sequencer import i2cms_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  i2cms_in_if.sink               in_ch,
  i2cms_out_if.source            out_ch,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_wdata
);

  // Phase length register.
  logic [TICK_W-1:0] phase_ticks_r;

  // Input register: one buffered tick.
  logic s1_valid_r;
  cmd_t s1_item_r;

  // Result register.
  logic out_valid_r;
  res_t res_r;
  res_t core_res;

  // Advance the buffered tick into the result register when there is room.
  logic adv;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  // Hold the tick until the core steps on it; refill in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.cmd_valid  <= in_ch.cmd_valid;
      s1_item_r.action     <= in_ch.action;
      s1_item_r.send_ack   <= in_ch.send_ack;
      s1_item_r.write_byte <= in_ch.write_byte;
      s1_item_r.sda_in     <= in_ch.sda_in;
    end
  end

  i2cms_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .item        (s1_item_r),
    .phase_ticks (phase_ticks_r),
    .res         (core_res)
  );

  // Load a fresh result on advance, drop the old one once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_level = res_r.scl_level;
  assign out_ch.sda_level = res_r.sda_level;
  assign out_ch.busy_res  = res_r.busy_res;
  assign out_ch.cmd_taken = res_r.cmd_taken;
  assign out_ch.done_res  = res_r.done_res;
  assign out_ch.read_byte = res_r.read_byte;
  assign out_ch.ack_seen  = res_r.ack_seen;

  // A finishing tick leaves the sequencer idle.
  `I2CMS_ASSERT_IMP(a_done_idle, out_valid_r && res_r.done_res, !res_r.busy_res)
  // A taken command always starts a busy period.
  `I2CMS_ASSERT_IMP(a_taken_busy, out_valid_r && res_r.cmd_taken, res_r.busy_res)
  // A buffered tick is never lost while the result side stalls.
  `I2CMS_ASSERT_NXT(a_s1_hold, s1_valid_r && !adv, s1_valid_r)

endmodule

`default_nettype wire

[dv/i2c_master_byte_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_tb
// Self-checking bench for the byte-level I2C master sequencer.
// Streams bus ticks into the sequencer, each with an optional command and the
// level a slave puts on SDA. A cycle model of the sequencer predicts the
// SCL/SDA drives and the status of every tick. Each result transfer is
// compared field by field under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_tb;
  import i2cms_pkg::*;

  // How the simulated slave drives SDA for the length of one command.
  typedef enum logic [1:0] {
    SLAVE_RANDOM,
    SLAVE_PULLS_LOW,
    SLAVE_RELEASED
  } slave_drive_e;

  // Cycles to let the two-stage pipeline settle once nothing is expected.
  localparam int unsigned SETTLE_CYCLES  = 4;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [TICK_W-1:0] LONGEST_PHASE = 16'hFFFF;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  i2cms_in_if  in_ch ();
  i2cms_out_if out_ch ();

  i2c_master_byte_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer model state: configuration, timer, phase and line drives.
  // --------------------------------------------------------------------------
  logic [TICK_W-1:0]  ticks_per_phase;
  logic [TICK_W-1:0]  tick_cnt;
  logic [PHASE_W-1:0] phase;
  op_t                cur_op;
  logic               busy;
  logic [7:0]         shift_reg;
  logic               ack_to_send;
  logic               slave_acked;
  logic               scl_drv;
  logic               sda_drv;
  logic [7:0]         last_read;

  // Expected line states, oldest first.
  res_t pending_line_states [$];
  res_t oldest_state;

  bit          sender_gaps;
  bit          sink_stalls;
  int unsigned ticks_sent;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned ops_taken [4];
  int unsigned ignored_cmds;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply the line drives of phase p of the current command.
  function automatic void drive_phase(input logic [PHASE_W-1:0] p);
    if (cur_op == OP_START) begin
      case (p)
        0: sda_drv = 1'b1;
        1: scl_drv = 1'b1;
        2: sda_drv = 1'b0;
        default: scl_drv = 1'b0;
      endcase
    end else if (cur_op == OP_STOP) begin
      case (p)
        0: scl_drv = 1'b0;
        1: sda_drv = 1'b0;
        2: scl_drv = 1'b1;
        default: sda_drv = 1'b1;
      endcase
    end else if (p < PHASE_ACK_LOW) begin
      // Bit slots: even phase sets up SDA with SCL low, odd phase raises SCL.
      // The very first phase leaves SCL wherever the previous command left it.
      if (p[0]) begin
        scl_drv = 1'b1;
      end else begin
        if (p != 0) scl_drv = 1'b0;
        if (cur_op == OP_WRITE) sda_drv = shift_reg[3'd7 - p[3:1]];
        else if (p == 0) sda_drv = 1'b1;
      end
    end else if (p == PHASE_ACK_LOW) begin
      scl_drv = 1'b0;
      sda_drv = (cur_op == OP_WRITE) ? 1'b1 : ~ack_to_send;
    end else begin
      scl_drv = 1'b1;
    end
  endfunction

  // Advance the model by one bus tick and return the line state it produces.
  function automatic res_t next_line_state(input cmd_t c);
    int unsigned limit;
    logic        taken;
    logic        done;
    res_t        r;
    limit = (ticks_per_phase == 0) ? 1 : ticks_per_phase;
    taken = 1'b0;
    done  = 1'b0;
    if (!busy) begin
      if (c.cmd_valid) begin
        taken       = 1'b1;
        busy        = 1'b1;
        cur_op      = c.action;
        shift_reg   = (c.action == OP_WRITE) ? c.write_byte : 8'h00;
        ack_to_send = c.send_ack;
        phase       = '0;
        tick_cnt    = '0;
        drive_phase(phase);
      end
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= limit) begin
        tick_cnt = '0;
        phase    = phase + 1'b1;
        if (phase >= ((cur_op == OP_WRITE || cur_op == OP_READ) ? PHASES_BYTE
                                                                 : PHASES_COND)) begin
          // Byte commands park SCL low; SDA stays where the ack slot left it.
          if (cur_op == OP_WRITE || cur_op == OP_READ) scl_drv = 1'b0;
          if (cur_op == OP_READ) last_read = shift_reg;
          busy  = 1'b0;
          phase = '0;
          done  = 1'b1;
        end else begin
          drive_phase(phase);
        end
      end
    end
    // Sample SDA on the last tick of an SCL-high phase: read data bits or a write's ack.
    if (busy && !taken && phase[0] && (tick_cnt + 1 >= limit)) begin
      if (cur_op == OP_READ && phase < PHASE_ACK_LOW)
        shift_reg = {shift_reg[6:0], c.sda_in};
      else if (cur_op == OP_WRITE && phase == PHASE_ACK_HIGH)
        slave_acked = ~c.sda_in;
    end
    r.scl_level = scl_drv;
    r.sda_level = sda_drv;
    r.busy_res  = busy;
    r.cmd_taken = taken;
    r.done_res  = done;
    r.read_byte = last_read;
    r.ack_seen  = slave_acked;
    return r;
  endfunction

  function automatic logic sda_for(input slave_drive_e slave);
    case (slave)
      SLAVE_PULLS_LOW: return 1'b0;
      SLAVE_RELEASED:  return 1'b1;
      default:         return $urandom_range(0, 1);
    endcase
  endfunction

  function automatic slave_drive_e pick_slave();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return SLAVE_RANDOM;
    if (roll < 85) return SLAVE_PULLS_LOW;
    return SLAVE_RELEASED;
  endfunction

  function automatic cmd_t make_tick(input logic offer, input op_t op, input logic ack,
                                     input logic [7:0] data, input slave_drive_e slave);
    cmd_t c;
    c.cmd_valid  = offer;
    c.action     = op;
    c.send_ack   = ack;
    c.write_byte = data;
    c.sda_in     = sda_for(slave);
    return c;
  endfunction

  // A tick while a command runs; now and then it offers a command to be dropped.
  function automatic cmd_t busy_tick(input slave_drive_e slave, input int unsigned noise_pct);
    return make_tick($urandom_range(0, 99) < noise_pct, op_t'($urandom_range(0, 3)),
                     $urandom_range(0, 1), $urandom_range(0, 255), slave);
  endfunction

  // --------------------------------------------------------------------------
  // Send one tick: optional sender gap, hold it until the transfer happens,
  // then predict its line state. valid is left high on return; the next call
  // or a drain takes it over.
  // --------------------------------------------------------------------------
  task automatic send_tick(input cmd_t c);
    res_t r;
    if (sender_gaps && $urandom_range(0, 15) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= c.cmd_valid;
    in_ch.action     <= c.action;
    in_ch.send_ack   <= c.send_ack;
    in_ch.write_byte <= c.write_byte;
    in_ch.sda_in     <= c.sda_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = next_line_state(c);
    pending_line_states.push_back(r);
    ticks_sent++;
    if (r.cmd_taken) ops_taken[c.action]++;
    else if (c.cmd_valid) ignored_cmds++;
  endtask

  // Offer a command on an idle tick and keep ticking until it completes.
  task automatic run_command(input op_t op, input logic ack, input logic [7:0] data,
                             input slave_drive_e slave, input int unsigned noise_pct);
    send_tick(make_tick(1'b1, op, ack, data, slave));
    while (busy) send_tick(busy_tick(slave, noise_pct));
  endtask

  task automatic idle_ticks(input int unsigned n);
    repeat (n) send_tick(make_tick(1'b0, op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                                   $urandom_range(0, 255), SLAVE_RANDOM));
  endtask

  // Drop valid and hold until every expected line state has been checked.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_line_states.size() != 0);
  endtask

  // Change the phase length with nothing left in the pipeline.
  task automatic set_phase_ticks(input logic [TICK_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we          <= 1'b0;
    ticks_per_phase  = value;
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Full transaction at the reset phase length with data and ack extremes.
  task automatic test_reset_length_transaction();
    run_command(OP_START, 1'b0, 8'h00, SLAVE_RANDOM, 0);
    run_command(OP_WRITE, 1'b0, 8'hFF, SLAVE_PULLS_LOW, 0);   // slave acks
    run_command(OP_WRITE, 1'b1, 8'h00, SLAVE_RELEASED, 0);    // slave never acks
    run_command(OP_READ, 1'b1, 8'hFF, SLAVE_PULLS_LOW, 0);    // all zeros, ACK
    run_command(OP_READ, 1'b0, 8'h00, SLAVE_RELEASED, 0);     // all ones, NAK
    run_command(OP_STOP, 1'b1, 8'hFF, SLAVE_RANDOM, 0);
  endtask

  // Byte commands straight after a stop: SDA moves while SCL is still high.
  task automatic test_bytes_without_start();
    run_command(OP_WRITE, 1'b0, 8'h5A, SLAVE_RANDOM, 0);
    run_command(OP_STOP, 1'b0, 8'h00, SLAVE_RANDOM, 0);
    run_command(OP_READ, 1'b1, 8'h00, SLAVE_RANDOM, 0);
    run_command(OP_START, 1'b0, 8'h00, SLAVE_RANDOM, 0);
    run_command(OP_START, 1'b1, 8'hA5, SLAVE_RANDOM, 0);      // repeated start
  endtask

  // Offer a command on every busy tick; all of them must be dropped.
  task automatic test_commands_while_busy();
    run_command(OP_WRITE, 1'b1, 8'hC3, SLAVE_RANDOM, 100);
    run_command(OP_READ, 1'b0, 8'h3C, SLAVE_RANDOM, 100);
    run_command(OP_STOP, 1'b0, 8'h00, SLAVE_RANDOM, 100);
  endtask

  // A phase length of zero must behave as one tick per phase.
  task automatic test_zero_phase_length();
    set_phase_ticks('0);
    run_command(OP_START, 1'b0, 8'h00, SLAVE_RANDOM, 20);
    run_command(OP_WRITE, 1'b0, 8'h81, SLAVE_PULLS_LOW, 20);
    run_command(OP_READ, 1'b1, 8'h00, SLAVE_RANDOM, 20);
    run_command(OP_READ, 1'b0, 8'h00, SLAVE_RANDOM, 20);
    run_command(OP_STOP, 1'b0, 8'h00, SLAVE_RANDOM, 20);
  endtask

  // Longest phase: start at 65535 ticks per phase and run a stretch of the
  // first phase, then cut the length to one mid-command so the timer, well
  // past the new length, advances at once and the rest plays out quickly.
  task automatic test_longest_phase();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    set_phase_ticks(LONGEST_PHASE);
    send_tick(make_tick(1'b1, OP_START, 1'b0, 8'h00, SLAVE_RANDOM));
    repeat (200) send_tick(busy_tick(SLAVE_RANDOM, 2));
    set_phase_ticks(16'd1);
    while (busy) send_tick(busy_tick(SLAVE_RANDOM, 2));
    run_command(OP_STOP, 1'b0, 8'h00, SLAVE_RANDOM, 0);
  endtask

  // Addressed transaction: start, address, 1..4 data bytes, stop or restart.
  task automatic random_transaction(input int unsigned noise_pct);
    logic [7:0]  addr;
    int unsigned nbytes;
    addr   = $urandom_range(0, 255);
    nbytes = $urandom_range(1, 4);
    run_command(OP_START, $urandom_range(0, 1), $urandom_range(0, 255), SLAVE_RANDOM,
                noise_pct);
    run_command(OP_WRITE, $urandom_range(0, 1), addr, pick_slave(), noise_pct);
    for (int i = 0; i < nbytes; i++) begin
      if (addr[0])  // read: ACK every byte but the last
        run_command(OP_READ, i != nbytes - 1, $urandom_range(0, 255), pick_slave(),
                    noise_pct);
      else
        run_command(OP_WRITE, $urandom_range(0, 1), $urandom_range(0, 255), pick_slave(),
                    noise_pct);
      idle_ticks($urandom_range(0, 2));
    end
    if ($urandom_range(0, 4) != 0)
      run_command(OP_STOP, $urandom_range(0, 1), $urandom_range(0, 255), SLAVE_RANDOM,
                  noise_pct);
  endtask

  // Mostly well-formed transactions, the rest stray commands and idle ticks.
  task automatic test_random_traffic(input logic [TICK_W-1:0] len, input int unsigned n,
                                     input bit gaps, input bit stalls);
    int unsigned stop_at;
    set_phase_ticks(len);
    sender_gaps = gaps;
    sink_stalls = stalls;
    stop_at     = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        random_transaction($urandom_range(0, 15));
      end else begin
        run_command(op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                    $urandom_range(0, 255), pick_slave(), $urandom_range(0, 50));
        idle_ticks($urandom_range(0, 5));
      end
      // Hold off now and then until the pipeline is empty, unless at full rate.
      if ((gaps || stalls) && $urandom_range(0, 24) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts while enabled, otherwise always ready.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_stalls && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result transfer against the oldest expected line state.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_line_states.size() == 0) begin
        $error("result transfer with no expected line state");
        mismatches++;
      end else begin
        oldest_state = pending_line_states.pop_front();
        check_field("scl_level", oldest_state.scl_level, out_ch.scl_level);
        check_field("sda_level", oldest_state.sda_level, out_ch.sda_level);
        check_field("busy_res", oldest_state.busy_res, out_ch.busy_res);
        check_field("cmd_taken", oldest_state.cmd_taken, out_ch.cmd_taken);
        check_field("done_res", oldest_state.done_res, out_ch.done_res);
        check_field("read_byte", oldest_state.read_byte, out_ch.read_byte);
        check_field("ack_seen", oldest_state.ack_seen, out_ch.ack_seen);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd_valid  <= 1'b0;
    in_ch.action     <= OP_START;
    in_ch.send_ack   <= 1'b0;
    in_ch.write_byte <= '0;
    in_ch.sda_in     <= 1'b1;
    idle_cycles      = 0;
    ticks_sent       = 0;
    mismatches       = 0;
    ignored_cmds     = 0;
    ops_taken        = '{default: 0};
    sender_gaps      = 1'b1;
    sink_stalls      = 1'b1;

    // Model comes out of reset with both lines released.
    ticks_per_phase = PHASE_TICKS_RST;
    tick_cnt        = '0;
    phase           = '0;
    cur_op          = OP_START;
    busy            = 1'b0;
    shift_reg       = '0;
    ack_to_send     = 1'b0;
    slave_acked     = 1'b0;
    scl_drv         = 1'b1;
    sda_drv         = 1'b1;
    last_read       = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length_transaction();
    test_bytes_without_start();
    test_commands_while_busy();
    test_zero_phase_length();
    test_longest_phase();
    test_random_traffic(16'd1, 250, 1'b1, 1'b1);
    test_random_traffic(16'd2, 200, 1'b0, 1'b1);
    test_random_traffic(16'd3, 200, 1'b1, 1'b0);
    test_random_traffic($urandom_range(1, 7), 150, 1'b1, 1'b1);
    // Last stretch runs at full rate with no idling on either side.
    test_random_traffic(16'd1, 200, 1'b0, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d ticks: %0d start, %0d stop, %0d write, %0d read, %0d dropped",
             ticks_sent, ops_taken[OP_START], ops_taken[OP_STOP], ops_taken[OP_WRITE],
             ops_taken[OP_READ], ignored_cmds);
    $display("phase lengths 0 to 65535, slave ack and nak, gaps and stalls on both sides");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[i2c_master_byte_sequencer.f]
+incdir+src
src/i2cms_pkg.sv
src/i2cms_in_if.sv
src/i2cms_out_if.sv
src/i2cms_core.sv
src/i2c_master_byte_sequencer.sv
dv/i2c_master_byte_sequencer_tb.sv
